[design/fwm_pkg.sv]
`timescale 1ns / 1ps
package fwm_pkg;

   localparam int VAL_W = 30;

   // Operation codes carried in the kind field.
   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_POP   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] median;
      logic [1:0]       status;
   } rsp_type;

endpackage

[design/fwm_ram.sv]
`timescale 1ns / 1ps
module fwm_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fifo_window_median.sv]
`timescale 1ns / 1ps
// Sliding-window median.
//
// The req channel carries one word per operation: push a value at the tail
// of the window, pop the oldest value, or query the median. Every accepted
// word produces exactly one rsp word, in order, holding the median (on a
// successful query, else zero) and a status code: ok, window empty, or
// window full with the pushed value dropped. A kind code with no meaning is
// a no-op that answers ok.
//
// The block takes one word per cycle while the receiver does not stall,
// and answers through the s1, s2 and result registers. Pushed values
// go into a ring buffer in RAM and into a row of sorted cells; each cell
// compares against the broadcast value and shifts by one place, so an
// insert or delete updates every cell at once. Pops read the ring via its
// read register. A two-level registered OR tree picks the median.
//
// Reset empties the window at once; no clearing pass is needed. When the
// receiver stalls, the whole pipeline freezes and req_ready drops in the
// same cycle, so nothing is lost or repeated.
module fifo_window_median #(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fwm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fwm_pkg::rsp_type rsp_data
);

   import fwm_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int GS = 64;
   localparam int NG = (DEPTH + GS - 1) / GS;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       query;
      logic [1:0] status;
   } op_ctl_type;

   // Pipeline control.
   logic advance;
   logic accept;

   // Window bookkeeping.
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW:0]   tail_sum;
   logic [AW-1:0] tail_slot;
   op_ctl_type    ctl0;

   // Stage 1: cell update and first level of the median select.
   logic             s1_vld_ff;
   op_ctl_type       s1_ctl_ff;
   logic [VAL_W-1:0] s1_val_ff;
   logic [CW-1:0]    s1_cnt_ff;
   logic [VAL_W-1:0] ram_rdata;
   logic [VAL_W-1:0] cmp_val;
   logic [CW-1:0]    mid_idx;
   logic [DEPTH-1:0] lt;
   logic [VAL_W-1:0] cell_ff [DEPTH];
   logic [VAL_W-1:0] cell_in [DEPTH];
   logic [VAL_W-1:0] grp_in  [NG];

   // Stage 2: second level of the median select.
   logic             s2_vld_ff;
   logic             s2_query_ff;
   logic [1:0]       s2_status_ff;
   logic [VAL_W-1:0] s2_grp_ff [NG];
   logic [VAL_W-1:0] pick;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Decode the operation against the window occupancy at acceptance.
   always_comb begin
      ctl0 = '0;
      unique case (req_data.kind)
         KIND_PUSH: begin
            if (count_ff == CW'(DEPTH)) begin
               ctl0.status = STAT_FULL;
            end else begin
               ctl0.push = 1'b1;
            end
         end
         KIND_POP: begin
            if (count_ff == '0) begin
               ctl0.status = STAT_EMPTY;
            end else begin
               ctl0.pop = 1'b1;
            end
         end
         KIND_QUERY: begin
            if (count_ff == '0) begin
               ctl0.status = STAT_EMPTY;
            end else begin
               ctl0.query = 1'b1;
            end
         end
         default: begin
            ctl0.status = STAT_OK;
         end
      endcase
   end

   // Tail slot is head plus count, wrapped once around the ring.
   always_comb begin
      tail_sum = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
      if (tail_sum >= (AW + 1)'(DEPTH)) begin
         tail_slot = AW'(tail_sum - (AW + 1)'(DEPTH));
      end else begin
         tail_slot = AW'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (accept && ctl0.push) begin
         count_in = count_ff + CW'(1);
      end
      if (accept && ctl0.pop) begin
         count_in = count_ff - CW'(1);
         if (head_ff == AW'(DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + AW'(1);
         end
      end
   end

   // The ring read always follows the head, so a pop finds the leaving
   // value in the read register when it reaches the cells.
   fwm_ram #(
      .WIDTH(VAL_W),
      .DEPTH(DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (accept && ctl0.push),
      .wr_addr(tail_slot),
      .wr_data(req_data.value),
      .rd_en  (advance),
      .rd_addr(head_ff),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (advance) begin
            s1_vld_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctl_ff <= ctl0;
         s1_val_ff <= req_data.value;
         s1_cnt_ff <= count_ff;
      end
   end

   // Sorted cells. Each cell only looks at itself and its two neighbors:
   // cells below the insert or delete point keep their value, the rest
   // shift up for an insert or down for a delete. Equal values are
   // interchangeable, so a delete removes the first copy.
   assign cmp_val = s1_ctl_ff.pop ? ram_rdata : s1_val_ff;
   assign mid_idx = s1_cnt_ff >> 1;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (CW'(i) < s1_cnt_ff) && (cell_ff[i] < cmp_val);
      end
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (!lt[i]) begin
            if (s1_ctl_ff.push) begin
               if (i == 0) begin
                  cell_in[i] = s1_val_ff;
               end else if (lt[i-1]) begin
                  cell_in[i] = s1_val_ff;
               end else begin
                  cell_in[i] = cell_ff[i-1];
               end
            end else if (s1_ctl_ff.pop && (i < DEPTH - 1)) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_vld_ff && (s1_ctl_ff.push || s1_ctl_ff.pop)) begin
         for (int i = 0; i < DEPTH; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   // First select level: one OR per group of cells, only the middle cell
   // passes its value.
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GS; j++) begin
            if ((g * GS + j) < DEPTH) begin
               if (CW'(g * GS + j) == mid_idx) begin
                  grp_in[g] = grp_in[g] | cell_ff[g * GS + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_query_ff  <= s1_ctl_ff.query;
         s2_status_ff <= s1_ctl_ff.status;
         for (int g = 0; g < NG; g++) begin
            s2_grp_ff[g] <= grp_in[g];
         end
      end
   end

   always_comb begin
      pick = '0;
      for (int g = 0; g < NG; g++) begin
         pick = pick | s2_grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.median <= s2_query_ff ? pick : '0;
         rsp_data_ff.status <= s2_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Verification of the sliding-window median block.
//
// A tracker object mirrors the window: it keeps its own ring of held values
// in arrival order and its own sorted copy of them. Every word that the
// block accepts on the req channel is run through the tracker, which works
// out the answer and queues it. Every word that leaves on the rsp channel is
// compared, field by field, with the oldest queued answer.
module testbench;
   import fwm_pkg::*;

   localparam int DEPTH      = 1024;
   localparam int QUIET_MAX  = 4000;   // cycles with no handshake before giving up
   localparam int GAP_PCT    = 32;     // chance in a hundred of an idle cycle
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
   // Kind code with no operation behind it.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Window tracker: predicts each answer and checks what the block returns.
   class median_tracker;
      logic [VAL_W-1:0] ring [DEPTH];
      logic [VAL_W-1:0] sorted [DEPTH];
      int unsigned      head;
      int unsigned      held;
      rsp_type          answers [$];
      int               mismatches;

      function new();
         head = 0;
         held = 0;
         mismatches = 0;
      endfunction

      // First sorted position whose value is not below v.
      function int unsigned lower_pos(logic [VAL_W-1:0] v);
         int unsigned p;
         p = 0;
         while (p < held && sorted[p] < v)
            p++;
         return p;
      endfunction

      function void note_word(req_type w);
         rsp_type     a;
         int unsigned p;
         a.median = '0;
         a.status = STAT_OK;
         case (w.kind)
            KIND_PUSH: begin
               if (held >= DEPTH) begin
                  a.status = STAT_FULL;
               end else begin
                  ring[(head + held) % DEPTH] = w.value;
                  p = lower_pos(w.value);
                  for (int unsigned i = held; i > p; i--)
                     sorted[i] = sorted[i-1];
                  sorted[p] = w.value;
                  held++;
               end
            end
            KIND_POP: begin
               if (held == 0) begin
                  a.status = STAT_EMPTY;
               end else begin
                  p = lower_pos(ring[head]);
                  for (int unsigned i = p; i + 1 < held; i++)
                     sorted[i] = sorted[i+1];
                  head = (head + 1) % DEPTH;
                  held--;
               end
            end
            KIND_QUERY: begin
               if (held == 0)
                  a.status = STAT_EMPTY;
               else
                  a.median = sorted[held / 2];
            end
            default: begin
            end
         endcase
         answers.push_back(a);
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (answers.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, median %0d status %0d",
                     $time, got.median, got.status);
         end else begin
            want = answers.pop_front();
            if (got.median !== want.median) begin
               mismatches++;
               $display("%0t: median mismatch, expected %0d, actual %0d",
                        $time, want.median, got.median);
            end
            if (got.status !== want.status) begin
               mismatches++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, got.status);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   median_tracker tracker;
   int            quiet = 0;
   logic          calm;   // high while neither side may idle

   fifo_window_median #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // All handshakes are observed here, at the rising edge, in one process.
   // An accepted req word is predicted before any rsp word of the same edge
   // is checked, so the order of events within a step does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_word(req_data);
         if (rsp_valid && rsp_ready)
            tracker.check_word(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
   end

   // The receiver stalls at random, except during the calm stretch.
   always @(negedge clock) begin
      if (!reset)
         rsp_ready = calm || ($urandom_range(99) >= GAP_PCT);
   end

   // A run that stops moving ends here.
   initial begin
      wait (quiet >= QUIET_MAX);
      $display("testbench failed");
      $finish;
   end

   // Offers one word. Called at a falling edge; returns at the falling edge
   // after the word has been taken. Valid stays high between back-to-back
   // words, so it is never dropped and raised in the same step.
   task automatic send_word(input logic [1:0] kind, input logic [VAL_W-1:0] value);
      while (!calm && $urandom_range(99) < GAP_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data.kind  = kind;
      req_data.value = value;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   // Values are drawn so that duplicates and the ends of the range are
   // common, while every bit of the field still toggles often.
   function automatic logic [VAL_W-1:0] pick_value();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(3))
         0: return VAL_W'($urandom_range(7));
         1: return $urandom_range(1) ? VAL_MAX : '0;
         default: return r[VAL_W-1:0];
      endcase
   endfunction

   // Draws one operation with the given weights (in percent); what is left
   // over goes to the unused kind code.
   task automatic send_random(input int push_pct, input int pop_pct, input int query_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct)
         send_word(KIND_PUSH, pick_value());
      else if (r < push_pct + pop_pct)
         send_word(KIND_POP, pick_value());
      else if (r < push_pct + pop_pct + query_pct)
         send_word(KIND_QUERY, pick_value());
      else
         send_word(KIND_UNUSED, pick_value());
   endtask

   initial begin
      tracker   = new();
      calm      = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: empty window on pop and query, the ends of the value
      // range, duplicates, the unused kind code, and a window that empties
      // and fills again.
      send_word(KIND_QUERY, VAL_MAX);
      send_word(KIND_POP, '0);
      send_word(KIND_PUSH, '0);
      send_word(KIND_PUSH, VAL_MAX);
      send_word(KIND_QUERY, '0);
      send_word(KIND_PUSH, VAL_MAX);
      send_word(KIND_PUSH, '0);
      send_word(KIND_QUERY, '0);
      send_word(KIND_UNUSED, VAL_MAX);
      send_word(KIND_POP, VAL_MAX);
      send_word(KIND_QUERY, '0);
      send_word(KIND_POP, '0);
      send_word(KIND_POP, '0);
      send_word(KIND_POP, '0);
      send_word(KIND_POP, '0);
      send_word(KIND_QUERY, '0);
      send_word(KIND_PUSH, VAL_W'(5));
      send_word(KIND_PUSH, VAL_W'(5));
      send_word(KIND_PUSH, VAL_W'(3));
      send_word(KIND_QUERY, '0);
      send_word(KIND_POP, '0);
      send_word(KIND_POP, '0);
      send_word(KIND_POP, '0);
      send_word(KIND_UNUSED, '0);

      // Churn around a small window, so that it runs dry again and again.
      for (int n = 0; n < 60; n++)
         send_random(40, 35, 20);

      // Fill the window to the top with queries and a few pops mixed in.
      // Both sides run without gaps while the window holds 300 to 599 values.
      while (tracker.held < DEPTH) begin
         calm = (tracker.held >= 300 && tracker.held < 600);
         send_random(90, 3, 6);
      end
      calm = 1'b0;

      // At the top: pushes are dropped, pops make room for a few more.
      for (int n = 0; n < 30; n++)
         send_random(55, 15, 28);

      req_valid = 1'b0;
      while (tracker.answers.size() != 0)
         @(posedge clock);
      // Room for any stray word the block might still send.
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

[files.f]
design/fwm_pkg.sv
design/fwm_ram.sv
design/fifo_window_median.sv
bench/testbench.sv
